// File: rtl/lca_pkg.sv
package lca_pkg;

    localparam int WORD_W    = 32;
    localparam int CHUNK_W   = 32;
    localparam int MUL_LAT   = 4;
    localparam int DIV_STEPS = 32;

    localparam logic [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_PARALLEL = 1'b1;

    typedef struct packed {
        logic signed [WORD_W-1:0] p1_x;
        logic signed [WORD_W-1:0] p1_y;
        logic signed [WORD_W-1:0] p1_z;
        logic signed [WORD_W-1:0] p2_x;
        logic signed [WORD_W-1:0] p2_y;
        logic signed [WORD_W-1:0] p2_z;
        logic signed [WORD_W-1:0] d1_x;
        logic signed [WORD_W-1:0] d1_y;
        logic signed [WORD_W-1:0] d1_z;
        logic signed [WORD_W-1:0] d2_x;
        logic signed [WORD_W-1:0] d2_y;
        logic signed [WORD_W-1:0] d2_z;
    } lca_in_t;

    typedef struct packed {
        logic        [WORD_W-2:0] distance;
        logic signed [WORD_W-1:0] vertex_x;
        logic signed [WORD_W-1:0] vertex_y;
        logic signed [WORD_W-1:0] vertex_z;
        logic                     status;
    } lca_out_t;

endpackage

// File: rtl/lca_mul.sv
module lca_mul
    import lca_pkg::*;
#(
    parameter int AW = WORD_W,
    parameter int BW = WORD_W
)
(
    input  logic                  clk,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA     = (AW + CHUNK_W - 1) / CHUNK_W;
    localparam int NB     = (BW + CHUNK_W - 1) / CHUNK_W;
    localparam int UA     = NA * CHUNK_W;
    localparam int UB     = NB * CHUNK_W;
    localparam int PW     = AW + BW;
    localparam int ROW_W  = CHUNK_W + UB;
    localparam int FULL_W = UA + UB;

    logic [AW-1:0]          abs_a;
    logic [BW-1:0]          abs_b;
    logic [UA-1:0]          ma_reg;
    logic [UB-1:0]          mb_reg;
    logic [2:0]             neg_reg;
    logic [2*CHUNK_W-1:0]   pp_reg [NA][NB];
    logic [ROW_W-1:0]       row_next [NA];
    logic [ROW_W-1:0]       row_reg [NA];
    logic [FULL_W-1:0]      full_next;
    logic signed [PW-1:0]   p_reg;

    assign abs_a = a[AW-1] ? -a : a;
    assign abs_b = b[BW-1] ? -b : b;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (j * CHUNK_W));
            end
        end
        full_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            full_next = full_next + (FULL_W'(row_reg[i]) << (i * CHUNK_W));
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= UA'(abs_a);
        mb_reg  <= UB'(abs_b);
        neg_reg <= {neg_reg[1:0], a[AW-1] ^ b[BW-1]};
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= (2*CHUNK_W)'(ma_reg[i*CHUNK_W +: CHUNK_W])
                              * (2*CHUNK_W)'(mb_reg[j*CHUNK_W +: CHUNK_W]);
            end
        end
        row_reg <= row_next;
        p_reg   <= neg_reg[2] ? -PW'(full_next) : PW'(full_next);
    end

    assign p = p_reg;

endmodule

// File: rtl/line_closest_approach_3d.sv
// Closest approach of two 3D lines, fully pipelined.
// Throughput: one word per clock cycle; busy stays low and the receiver cannot stall.
// Depth is set by the two four-stage multiplier levels and the 32-step divide/root pipeline.
// Reset clears the valid pipeline only; no word in flight survives reset.
module line_closest_approach_3d
    import lca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  lca_in_t  operands,
    output logic     done,
    output lca_out_t result
);

    localparam int PIPE_DEPTH = 48;
    localparam int R_W     = WORD_W + 1;
    localparam int PR_W    = 2 * WORD_W + 1;
    localparam int SUM_W   = PR_W + 2;
    localparam int M2_W    = 2 * SUM_W;
    localparam int DET_W   = M2_W + 1;
    localparam int GP_W    = R_W + SUM_W;
    localparam int G_W     = GP_W + 2;
    localparam int DS_W    = DET_W + R_W;
    localparam int NV_W    = DET_W + WORD_W;
    localparam int GG_W    = 2 * G_W;
    localparam int NUM_W   = DS_W + 2;
    localparam int DN_W    = DET_W;
    localparam int VREM_W  = NUM_W + 1;
    localparam int DREM_W  = GG_W + 2;
    localparam int P_W     = DN_W + DIV_STEPS;

    logic [PIPE_DEPTH-1:0] vld_reg;
    lca_in_t               op_reg;

    logic signed [WORD_W-1:0] p1_w [3];
    logic signed [WORD_W-1:0] p2_w [3];
    logic signed [WORD_W-1:0] d1_w [3];
    logic signed [WORD_W-1:0] d2_w [3];

    logic signed [R_W-1:0]    r2_reg [3];
    logic signed [R_W-1:0]    s2_reg [3];
    logic signed [WORD_W-1:0] d1_2_reg [3];
    logic signed [WORD_W-1:0] d2_2_reg [3];

    logic signed [PR_W-1:0]   cp3_reg [3];
    logic signed [PR_W-1:0]   m1p3_reg [3];
    logic signed [PR_W-1:0]   m2p3_reg [3];
    logic signed [PR_W-1:0]   ap3_reg [3];
    logic signed [PR_W-1:0]   bp3_reg [3];
    logic signed [PR_W-1:0]   xa3_reg [3];
    logic signed [PR_W-1:0]   xb3_reg [3];
    logic signed [R_W-1:0]    r3_reg [3];
    logic signed [R_W-1:0]    s3_reg [3];
    logic signed [WORD_W-1:0] d1_3_reg [3];
    logic signed [WORD_W-1:0] d2_3_reg [3];

    logic signed [SUM_W-1:0]  c4_reg;
    logic signed [SUM_W-1:0]  m1_4_reg;
    logic signed [SUM_W-1:0]  m2_4_reg;
    logic signed [SUM_W-1:0]  a4_reg;
    logic signed [SUM_W-1:0]  b4_reg;
    logic signed [SUM_W-1:0]  n4_reg [3];
    logic signed [R_W-1:0]    r4_reg [3];
    logic signed [R_W-1:0]    s4_reg [3];
    logic signed [WORD_W-1:0] d1_4_reg [3];
    logic signed [WORD_W-1:0] d2_4_reg [3];

    logic signed [M2_W-1:0]   cc_p;
    logic signed [M2_W-1:0]   mm_p;
    logic signed [M2_W-1:0]   m2a_p;
    logic signed [M2_W-1:0]   cb_p;
    logic signed [M2_W-1:0]   ca_p;
    logic signed [M2_W-1:0]   m1b_p;
    logic signed [GP_W-1:0]   g_p [3];

    logic signed [R_W-1:0]    s_dl_reg  [MUL_LAT][3];
    logic signed [WORD_W-1:0] d1_dl_reg [MUL_LAT][3];
    logic signed [WORD_W-1:0] d2_dl_reg [MUL_LAT][3];

    logic signed [DET_W-1:0]  det9_reg;
    logic signed [DET_W-1:0]  n1_9_reg;
    logic signed [DET_W-1:0]  n2_9_reg;
    logic signed [G_W-1:0]    g9_reg;
    logic signed [R_W-1:0]    s9_reg [3];
    logic signed [WORD_W-1:0] d1_9_reg [3];
    logic signed [WORD_W-1:0] d2_9_reg [3];

    logic signed [DS_W-1:0]   ds_p [3];
    logic signed [NV_W-1:0]   n1v_p [3];
    logic signed [NV_W-1:0]   n2v_p [3];
    logic signed [GG_W-1:0]   gg_p;
    logic [DN_W-1:0]          dn_dl_reg [MUL_LAT];
    logic                     par_dl_reg [MUL_LAT];

    logic signed [NUM_W-1:0]  num14_reg [3];
    logic signed [GG_W-1:0]   gg14_reg;
    logic [DN_W-1:0]          dn14_reg;
    logic                     par14_reg;

    logic signed [VREM_W-1:0] dn_ext;
    logic signed [VREM_W-1:0] num_ext [3];
    logic signed [VREM_W-1:0] vrem_next [3];

    logic [VREM_W-1:0]    vrem_st_reg [DIV_STEPS+1][3];
    logic [WORD_W-1:0]    vq_st_reg   [DIV_STEPS+1][3];
    logic                 neg_st_reg  [DIV_STEPS+1][3];
    logic [DREM_W-1:0]    drem_st_reg [DIV_STEPS+1];
    logic [P_W-1:0]       dp_st_reg   [DIV_STEPS+1];
    logic [WORD_W-1:0]    dq_st_reg   [DIV_STEPS+1];
    logic [DN_W-1:0]      dn_st_reg   [DIV_STEPS+1];
    logic                 par_st_reg  [DIV_STEPS+1];

    logic signed [WORD_W-1:0] vtx_next [3];
    lca_out_t                 result_next;
    lca_out_t                 result_reg;

    assign busy = 1'b0;
    assign done = vld_reg[PIPE_DEPTH-1];
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start};
        end
    end

    assign p1_w[0] = op_reg.p1_x;
    assign p1_w[1] = op_reg.p1_y;
    assign p1_w[2] = op_reg.p1_z;
    assign p2_w[0] = op_reg.p2_x;
    assign p2_w[1] = op_reg.p2_y;
    assign p2_w[2] = op_reg.p2_z;
    assign d1_w[0] = op_reg.d1_x;
    assign d1_w[1] = op_reg.d1_y;
    assign d1_w[2] = op_reg.d1_z;
    assign d2_w[0] = op_reg.d2_x;
    assign d2_w[1] = op_reg.d2_y;
    assign d2_w[2] = op_reg.d2_z;

    // Front end: differences and sums of the points, per-axis and cross-axis products, and their sums.
    always_ff @(posedge clk)
    begin
        op_reg <= operands;
        for (int i = 0; i < 3; i++)
        begin
            r2_reg[i]   <= R_W'(p1_w[i]) - R_W'(p2_w[i]);
            s2_reg[i]   <= R_W'(p1_w[i]) + R_W'(p2_w[i]);
            d1_2_reg[i] <= d1_w[i];
            d2_2_reg[i] <= d2_w[i];

            cp3_reg[i]  <= PR_W'(d1_2_reg[i]) * PR_W'(d2_2_reg[i]);
            m1p3_reg[i] <= PR_W'(d1_2_reg[i]) * PR_W'(d1_2_reg[i]);
            m2p3_reg[i] <= PR_W'(d2_2_reg[i]) * PR_W'(d2_2_reg[i]);
            ap3_reg[i]  <= PR_W'(r2_reg[i]) * PR_W'(d1_2_reg[i]);
            bp3_reg[i]  <= PR_W'(r2_reg[i]) * PR_W'(d2_2_reg[i]);
            xa3_reg[i]  <= PR_W'(d1_2_reg[(i+1)%3]) * PR_W'(d2_2_reg[(i+2)%3]);
            xb3_reg[i]  <= PR_W'(d1_2_reg[(i+2)%3]) * PR_W'(d2_2_reg[(i+1)%3]);
            r3_reg[i]   <= r2_reg[i];
            s3_reg[i]   <= s2_reg[i];
            d1_3_reg[i] <= d1_2_reg[i];
            d2_3_reg[i] <= d2_2_reg[i];

            n4_reg[i]   <= SUM_W'(xa3_reg[i]) - SUM_W'(xb3_reg[i]);
            r4_reg[i]   <= r3_reg[i];
            s4_reg[i]   <= s3_reg[i];
            d1_4_reg[i] <= d1_3_reg[i];
            d2_4_reg[i] <= d2_3_reg[i];
        end
        c4_reg   <= SUM_W'(cp3_reg[0]) + SUM_W'(cp3_reg[1]) + SUM_W'(cp3_reg[2]);
        m1_4_reg <= SUM_W'(m1p3_reg[0]) + SUM_W'(m1p3_reg[1]) + SUM_W'(m1p3_reg[2]);
        m2_4_reg <= SUM_W'(m2p3_reg[0]) + SUM_W'(m2p3_reg[1]) + SUM_W'(m2p3_reg[2]);
        a4_reg   <= SUM_W'(ap3_reg[0]) + SUM_W'(ap3_reg[1]) + SUM_W'(ap3_reg[2]);
        b4_reg   <= SUM_W'(bp3_reg[0]) + SUM_W'(bp3_reg[1]) + SUM_W'(bp3_reg[2]);
    end

    lca_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_cc  (.clk(clk), .a(c4_reg),   .b(c4_reg),   .p(cc_p));
    lca_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_mm  (.clk(clk), .a(m1_4_reg), .b(m2_4_reg), .p(mm_p));
    lca_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_m2a (.clk(clk), .a(m2_4_reg), .b(a4_reg),   .p(m2a_p));
    lca_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_cb  (.clk(clk), .a(c4_reg),   .b(b4_reg),   .p(cb_p));
    lca_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_ca  (.clk(clk), .a(c4_reg),   .b(a4_reg),   .p(ca_p));
    lca_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_m1b (.clk(clk), .a(m1_4_reg), .b(b4_reg),   .p(m1b_p));

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        lca_mul #(.AW(R_W), .BW(SUM_W)) u_mul_g
        (
            .clk (clk),
            .a   (r4_reg[l]),
            .b   (n4_reg[l]),
            .p   (g_p[l])
        );
        lca_mul #(.AW(DET_W), .BW(R_W)) u_mul_ds
        (
            .clk (clk),
            .a   (det9_reg),
            .b   (s9_reg[l]),
            .p   (ds_p[l])
        );
        lca_mul #(.AW(DET_W), .BW(WORD_W)) u_mul_n1v
        (
            .clk (clk),
            .a   (n1_9_reg),
            .b   (d1_9_reg[l]),
            .p   (n1v_p[l])
        );
        lca_mul #(.AW(DET_W), .BW(WORD_W)) u_mul_n2v
        (
            .clk (clk),
            .a   (n2_9_reg),
            .b   (d2_9_reg[l]),
            .p   (n2v_p[l])
        );
    end

    lca_mul #(.AW(G_W), .BW(G_W)) u_mul_gg (.clk(clk), .a(g9_reg), .b(g9_reg), .p(gg_p));

    // Determinant, numerators and the triple product, then the second product level.
    always_ff @(posedge clk)
    begin
        s_dl_reg[0]  <= s4_reg;
        d1_dl_reg[0] <= d1_4_reg;
        d2_dl_reg[0] <= d2_4_reg;
        dn_dl_reg[0]  <= DN_W'(-det9_reg);
        par_dl_reg[0] <= (det9_reg == '0);
        for (int k = 1; k < MUL_LAT; k++)
        begin
            s_dl_reg[k]   <= s_dl_reg[k-1];
            d1_dl_reg[k]  <= d1_dl_reg[k-1];
            d2_dl_reg[k]  <= d2_dl_reg[k-1];
            dn_dl_reg[k]  <= dn_dl_reg[k-1];
            par_dl_reg[k] <= par_dl_reg[k-1];
        end

        det9_reg <= DET_W'(cc_p) - DET_W'(mm_p);
        n1_9_reg <= DET_W'(m2a_p) - DET_W'(cb_p);
        n2_9_reg <= DET_W'(ca_p) - DET_W'(m1b_p);
        g9_reg   <= G_W'(g_p[0]) + G_W'(g_p[1]) + G_W'(g_p[2]);
        s9_reg   <= s_dl_reg[MUL_LAT-1];
        d1_9_reg <= d1_dl_reg[MUL_LAT-1];
        d2_9_reg <= d2_dl_reg[MUL_LAT-1];

        for (int i = 0; i < 3; i++)
        begin
            num14_reg[i] <= NUM_W'(ds_p[i]) + NUM_W'(n1v_p[i]) + NUM_W'(n2v_p[i]);
        end
        gg14_reg  <= gg_p;
        dn14_reg  <= dn_dl_reg[MUL_LAT-1];
        par14_reg <= par_dl_reg[MUL_LAT-1];
    end

    // The determinant is never positive, so the vertex is -num / (2 * dn).
    assign dn_ext = VREM_W'($signed({1'b0, dn14_reg}));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_ext[i]   = VREM_W'(num14_reg[i]);
            vrem_next[i] = num14_reg[i][NUM_W-1] ? (dn_ext - num_ext[i])
                                                 : (dn_ext + num_ext[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vrem_st_reg[0][i] <= VREM_W'(vrem_next[i]);
            vq_st_reg[0][i]   <= '0;
            neg_st_reg[0][i]  <= ~num14_reg[i][NUM_W-1];
        end
        drem_st_reg[0] <= DREM_W'(gg14_reg);
        dp_st_reg[0]   <= '0;
        dq_st_reg[0]   <= '0;
        dn_st_reg[0]   <= dn14_reg;
        par_st_reg[0]  <= par14_reg;
    end

    // Each step settles one quotient bit of the three vertex divisions and one root bit
    // of the distance, found as the largest y with y * y * dn not above g * g.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        localparam int K = DIV_STEPS - 1 - j;

        logic [VREM_W-1:0] vtrial;
        logic [DREM_W-1:0] dtrial;

        assign vtrial = VREM_W'(dn_st_reg[j]) << (K + 1);
        assign dtrial = (DREM_W'(dp_st_reg[j]) << (K + 1))
                      + (DREM_W'(dn_st_reg[j]) << (2 * K));

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (vrem_st_reg[j][i] >= vtrial)
                begin
                    vrem_st_reg[j+1][i] <= vrem_st_reg[j][i] - vtrial;
                    vq_st_reg[j+1][i]   <= vq_st_reg[j][i] | (WORD_W'(1) << K);
                end
                else
                begin
                    vrem_st_reg[j+1][i] <= vrem_st_reg[j][i];
                    vq_st_reg[j+1][i]   <= vq_st_reg[j][i];
                end
                neg_st_reg[j+1][i] <= neg_st_reg[j][i];
            end
            if (drem_st_reg[j] >= dtrial)
            begin
                drem_st_reg[j+1] <= drem_st_reg[j] - dtrial;
                dp_st_reg[j+1]   <= dp_st_reg[j] + (P_W'(dn_st_reg[j]) << K);
                dq_st_reg[j+1]   <= dq_st_reg[j] | (WORD_W'(1) << K);
            end
            else
            begin
                drem_st_reg[j+1] <= drem_st_reg[j];
                dp_st_reg[j+1]   <= dp_st_reg[j];
                dq_st_reg[j+1]   <= dq_st_reg[j];
            end
            dn_st_reg[j+1]  <= dn_st_reg[j];
            par_st_reg[j+1] <= par_st_reg[j];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (neg_st_reg[DIV_STEPS][i])
            begin
                vtx_next[i] = (vq_st_reg[DIV_STEPS][i] > S32_MIN) ? S32_MIN
                                                                  : -vq_st_reg[DIV_STEPS][i];
            end
            else
            begin
                vtx_next[i] = vq_st_reg[DIV_STEPS][i][WORD_W-1] ? S32_MAX
                                                                : vq_st_reg[DIV_STEPS][i];
            end
        end
        if (par_st_reg[DIV_STEPS])
        begin
            result_next.distance = '0;
            result_next.vertex_x = '0;
            result_next.vertex_y = '0;
            result_next.vertex_z = '0;
            result_next.status   = STATUS_PARALLEL;
        end
        else
        begin
            result_next.distance = dq_st_reg[DIV_STEPS][WORD_W-1] ? '1
                                                                  : dq_st_reg[DIV_STEPS][WORD_W-2:0];
            result_next.vertex_x = vtx_next[0];
            result_next.vertex_y = vtx_next[1];
            result_next.vertex_z = vtx_next[2];
            result_next.status   = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    a_word_completes: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_DEPTH done)
        else $error("Accepted word did not complete after the pipeline depth.");

    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_PARALLEL) |->
        (result.distance == '0 && result.vertex_x == '0 &&
         result.vertex_y == '0 && result.vertex_z == '0))
        else $error("Parallel result carries nonzero fields.");

    a_det_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[13] |-> (par14_reg == (dn14_reg == '0)))
        else $error("Parallel flag and determinant are out of step.");

endmodule
